// ===== hdl/salc_pkg.sv =====
package salc_pkg;

	typedef struct packed {
		logic [1:0]  operation;
		logic [63:0] address;
	} req_t;

	typedef struct packed {
		logic [1:0]  outcome;
		logic        modify_hit;
		logic [31:0] hit_total;
		logic [31:0] miss_total;
		logic [31:0] eviction_total;
	} rsp_t;

	localparam logic [1:0] OP_MODIFY = 2'd2;

	localparam logic [1:0] OUT_HIT   = 2'd0;
	localparam logic [1:0] OUT_FILL  = 2'd1;
	localparam logic [1:0] OUT_EVICT = 2'd2;

	localparam logic [1:0] REG_SET_BITS   = 2'd0;
	localparam logic [1:0] REG_WAYS       = 2'd1;
	localparam logic [1:0] REG_BLOCK_BITS = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOK,
		ST_RESP
	} state_t;

	typedef struct packed {
		logic capture;
		logic update;
	} cmd_t;

endpackage

// ===== hdl/salc_ctrl.sv =====
module salc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output salc_pkg::cmd_t    cmd
);

	salc_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= salc_pkg::ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			salc_pkg::ST_IDLE: if (in_valid) state_d = salc_pkg::ST_LOOK;
			salc_pkg::ST_LOOK: state_d = salc_pkg::ST_RESP;
			salc_pkg::ST_RESP: begin
				if (out_ready) state_d = in_valid ? salc_pkg::ST_LOOK : salc_pkg::ST_IDLE;
			end
			default: state_d = salc_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready    = (state_q == salc_pkg::ST_IDLE) ||
			(state_q == salc_pkg::ST_RESP && out_ready);
		out_valid   = (state_q == salc_pkg::ST_RESP);
		cmd.capture = in_valid && in_ready;
		cmd.update  = (state_q == salc_pkg::ST_LOOK);
	end

	// one beat in flight at most
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.update |=> out_valid) else $error("look not followed by response");
	a_cap: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> cmd.update) else $error("capture not followed by look");
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.update && out_valid)) else $error("look and response overlap");

endmodule

// ===== hdl/salc_dp.sv =====
module salc_dp #(
	parameter int MAX_SET_BITS = 6,
	parameter int MAX_WAYS     = 8,
	parameter int TAG_WIDTH    = 62
) (
	input  logic           clk,
	input  logic           arst_n,
	input  salc_pkg::cmd_t cmd,
	input  salc_pkg::req_t req,
	input  logic           cfg_we,
	input  logic [1:0]     cfg_index,
	input  logic [5:0]     cfg_data,
	output salc_pkg::rsp_t rsp
);

	localparam int NSETS = 1 << MAX_SET_BITS;
	localparam int WW    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int CW    = $clog2(MAX_WAYS + 1);

	logic [2:0] set_bits_q;
	logic [3:0] ways_q;
	logic [5:0] block_bits_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_bits_q   <= 3'd1;
			ways_q       <= 4'd1;
			block_bits_q <= 6'd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				salc_pkg::REG_SET_BITS:   set_bits_q   <= cfg_data[2:0];
				salc_pkg::REG_WAYS:       ways_q       <= cfg_data[3:0];
				salc_pkg::REG_BLOCK_BITS: block_bits_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// address split at capture
	logic [6:0]  total;
	logic [63:0] ashift, tshift;
	logic [3:0]  s_eff;
	logic [MAX_SET_BITS-1:0] set_c;
	logic [MAX_SET_BITS-1:0] smask;
	always_comb begin
		s_eff  = (32'(set_bits_q) > MAX_SET_BITS) ? 4'(MAX_SET_BITS) : 4'(set_bits_q);
		ashift = req.address >> block_bits_q;
		total  = 7'(s_eff) + 7'(block_bits_q);
		tshift = total[6] ? 64'd0 : (req.address >> total[5:0]);
		smask  = MAX_SET_BITS'(({{MAX_SET_BITS{1'b0}}, 1'b1} << s_eff) - 1'b1);
		set_c  = ashift[MAX_SET_BITS-1:0] & smask;
	end

	logic [MAX_SET_BITS-1:0] set_s1;
	logic [TAG_WIDTH-1:0]    tag_s1;
	logic                    mod_s1;
	logic [CW-1:0]           e_s1;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			set_s1 <= set_c;
			tag_s1 <= tshift[TAG_WIDTH-1:0];
			mod_s1 <= (req.operation == salc_pkg::OP_MODIFY);
			if (ways_q == 4'd0) e_s1 <= CW'(1);
			else if (32'(ways_q) > MAX_WAYS) e_s1 <= CW'(MAX_WAYS);
			else e_s1 <= CW'(ways_q);
		end
	end

	// tag memory: one row of MAX_WAYS tags per set, read at capture
	// valid ways form a prefix, so each set keeps only its fill count
	logic [MAX_WAYS*TAG_WIDTH-1:0] tag_mem [NSETS];
	logic [MAX_WAYS*TAG_WIDTH-1:0] row_s1;
	logic [CW-1:0]                 fill_q [NSETS];
	logic [CW-1:0]                 fill_s1;
	logic [MAX_WAYS-1:0]           vrow;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			row_s1  <= tag_mem[set_c];
			fill_s1 <= fill_q[set_c];
		end
	end

	always_comb begin
		for (int i = 0; i < MAX_WAYS; i++) vrow[i] = (CW'(i) < fill_s1);
	end

	// scan: first free or matching way
	logic [1:0]          outc;
	logic [WW-1:0]       pos;
	logic                found;
	always_comb begin
		outc  = salc_pkg::OUT_EVICT;
		pos   = '0;
		found = 1'b0;
		for (int i = 0; i < MAX_WAYS; i++) begin
			if (!found && CW'(i) < e_s1) begin
				if (!vrow[i]) begin
					outc = salc_pkg::OUT_FILL; pos = WW'(i); found = 1'b1;
				end else if (row_s1[i*TAG_WIDTH +: TAG_WIDTH] == tag_s1) begin
					outc = salc_pkg::OUT_HIT; pos = WW'(i); found = 1'b1;
				end
			end
		end
	end

	// rebuilt row: on hit or evict, ways at or above pos take their successor while valid
	logic [MAX_WAYS*TAG_WIDTH-1:0] new_row;
	always_comb begin
		new_row = row_s1;
		for (int i = 0; i < MAX_WAYS; i++) begin
			if (CW'(i) < e_s1 && WW'(i) >= pos && outc != salc_pkg::OUT_FILL) begin
				if (i + 1 < MAX_WAYS && CW'(i + 1) < e_s1 && vrow[(i + 1) % MAX_WAYS])
					new_row[i*TAG_WIDTH +: TAG_WIDTH] =
						row_s1[((i + 1) % MAX_WAYS)*TAG_WIDTH +: TAG_WIDTH];
				else
					new_row[i*TAG_WIDTH +: TAG_WIDTH] = tag_s1;
			end
		end
		if (outc == salc_pkg::OUT_FILL) begin
			new_row[pos*TAG_WIDTH +: TAG_WIDTH] = tag_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.update) tag_mem[set_s1] <= new_row;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NSETS; k++) fill_q[k] <= '0;
		end else if (cmd.update && outc == salc_pkg::OUT_FILL) begin
			fill_q[set_s1] <= fill_s1 + CW'(1);
		end
	end

	// saturating totals
	logic [31:0] hit_q, miss_q, evict_q;
	logic [31:0] h1, h2;
	always_comb begin
		h1 = (outc == salc_pkg::OUT_HIT && hit_q != '1) ? hit_q + 32'd1 : hit_q;
		h2 = (mod_s1 && h1 != '1) ? h1 + 32'd1 : h1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= '0; miss_q <= '0; evict_q <= '0;
		end else if (cmd.update) begin
			hit_q <= h2;
			if (outc != salc_pkg::OUT_HIT && miss_q != '1) miss_q <= miss_q + 32'd1;
			if (outc == salc_pkg::OUT_EVICT && evict_q != '1) evict_q <= evict_q + 32'd1;
		end
	end

	logic [1:0] outc_q;
	logic       mod_q;
	always_ff @(posedge clk) begin
		if (cmd.update) begin
			outc_q <= outc;
			mod_q  <= mod_s1;
		end
	end

	assign rsp.outcome        = outc_q;
	assign rsp.modify_hit     = mod_q;
	assign rsp.hit_total      = hit_q;
	assign rsp.miss_total     = miss_q;
	assign rsp.eviction_total = evict_q;

	a_mono: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.update |=> hit_q >= $past(hit_q)) else $error("hit total dropped");
	a_ev: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.update && outc == salc_pkg::OUT_EVICT) |-> vrow[0])
		else $error("eviction with free head way");
	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.update && outc == salc_pkg::OUT_FILL) |=> fill_q[$past(set_s1)] != '0)
		else $error("fill left set empty");

endmodule

// ===== hdl/set_assoc_lru_cache_sim.sv =====
// Sequence: an accepted beat is captured (address split, set row read), then
// compared and the reordered set row written back, then its result is held until taken.
// A new access is accepted only while idle or as the previous response is taken,
// set by the single read-modify-write of the set row in the tag memory.
// Reset: arst_n clears every set's fill count (all lines invalid), the three totals
// and the registers (set_bits 1, ways_in_use 1, block_bits 1); stored tags are kept.
module set_assoc_lru_cache_sim #(
	parameter int MAX_SET_BITS = 6,
	parameter int MAX_WAYS     = 8,
	parameter int TAG_WIDTH    = 62
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  salc_pkg::req_t in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output salc_pkg::rsp_t out_data,
	input  logic           cfg_we,
	input  logic [1:0]     cfg_index,
	input  logic [5:0]     cfg_data
);

	salc_pkg::cmd_t cmd;

	// sequence capture, lookup/update, and response hold
	salc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.cmd      (cmd)
	);

	// address split, tag rows, LRU reorder and totals
	salc_dp #(
		.MAX_SET_BITS(MAX_SET_BITS),
		.MAX_WAYS    (MAX_WAYS),
		.TAG_WIDTH   (TAG_WIDTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.req      (in_data),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.rsp      (out_data)
	);

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

	localparam int SETS_MAX  = 64;
	localparam int WAYS_MAX  = 8;
	localparam int TAG_W     = 62;
	localparam int RAND_BEATS = 2000;
	localparam longint CYCLE_LIMIT = 400000;

	// Cache predictor and queue of expected responses
	class lru_scoreboard;
		bit            valid_q [SETS_MAX*WAYS_MAX];
		bit [TAG_W-1:0] tag_q  [SETS_MAX*WAYS_MAX];
		bit [31:0]     hits, misses, evicts;
		bit [2:0]      set_bits;
		bit [3:0]      ways;
		bit [5:0]      block_bits;
		salc_pkg::rsp_t pending [$];
		int            errors;

		function new();
			foreach (valid_q[i]) begin
				valid_q[i] = 0;
				tag_q[i] = '0;
			end
			hits = 0; misses = 0; evicts = 0;
			set_bits = 1; ways = 1; block_bits = 1;
			pending = {};
			errors = 0;
		endfunction

		function bit [31:0] bump(bit [31:0] v);
			return (v == 32'hFFFF_FFFF) ? v : v + 1;
		endfunction

		function void write_reg(bit [1:0] idx, bit [5:0] val);
			case (idx)
				salc_pkg::REG_SET_BITS:   set_bits = val[2:0];
				salc_pkg::REG_WAYS:       ways = val[3:0];
				salc_pkg::REG_BLOCK_BITS: block_bits = val;
				default: ;
			endcase
		endfunction

		// Predict the response to one accepted request
		function void note_access(salc_pkg::req_t rq);
			int s, e, b, i, base, idx;
			bit [63:0] set_ix, tg;
			bit [1:0] oc;
			salc_pkg::rsp_t r;
			s = (set_bits > 6) ? 6 : set_bits;
			e = (ways == 0) ? 1 : ((ways > WAYS_MAX) ? WAYS_MAX : ways);
			b = block_bits;
			set_ix = (rq.address >> b) & ((64'd1 << s) - 1);
			tg = (s + b < 64) ? (rq.address >> (s + b)) : 64'd0;
			base = int'(set_ix) * WAYS_MAX;
			oc = salc_pkg::OUT_EVICT;
			idx = 0;
			for (i = 0; i < e; i++) begin
				if (!valid_q[base+i]) begin
					oc = salc_pkg::OUT_FILL; idx = i; break;
				end
				if (tag_q[base+i] == tg[TAG_W-1:0]) begin
					oc = salc_pkg::OUT_HIT; idx = i; break;
				end
			end
			if (oc == salc_pkg::OUT_HIT) begin
				while (idx + 1 < e && valid_q[base+idx+1]) begin
					tag_q[base+idx] = tag_q[base+idx+1];
					idx++;
				end
				tag_q[base+idx] = tg[TAG_W-1:0];
				hits = bump(hits);
			end else if (oc == salc_pkg::OUT_FILL) begin
				tag_q[base+idx] = tg[TAG_W-1:0];
				valid_q[base+idx] = 1;
				misses = bump(misses);
			end else begin
				for (i = 0; i + 1 < e; i++) tag_q[base+i] = tag_q[base+i+1];
				tag_q[base+e-1] = tg[TAG_W-1:0];
				misses = bump(misses);
				evicts = bump(evicts);
			end
			if (rq.operation == salc_pkg::OP_MODIFY) hits = bump(hits);
			r.outcome = oc;
			r.modify_hit = (rq.operation == salc_pkg::OP_MODIFY);
			r.hit_total = hits;
			r.miss_total = misses;
			r.eviction_total = evicts;
			pending.push_back(r);
		endfunction

		function void check_beat(salc_pkg::rsp_t got);
			salc_pkg::rsp_t w;
			if (pending.size() == 0) begin
				$error("response beat with nothing pending");
				errors++;
				return;
			end
			w = pending.pop_front();
			if (got.outcome !== w.outcome) begin
				$error("outcome exp %0d got %0d", w.outcome, got.outcome); errors++;
			end
			if (got.modify_hit !== w.modify_hit) begin
				$error("modify_hit exp %0d got %0d", w.modify_hit, got.modify_hit); errors++;
			end
			if (got.hit_total !== w.hit_total) begin
				$error("hit_total exp %0d got %0d", w.hit_total, got.hit_total); errors++;
			end
			if (got.miss_total !== w.miss_total) begin
				$error("miss_total exp %0d got %0d", w.miss_total, got.miss_total); errors++;
			end
			if (got.eviction_total !== w.eviction_total) begin
				$error("eviction_total exp %0d got %0d", w.eviction_total,
					got.eviction_total);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_ready;
	salc_pkg::req_t in_data = '0;
	logic out_valid;
	logic out_ready = 0;
	salc_pkg::rsp_t out_data;
	logic cfg_we = 0;
	logic [1:0] cfg_index = '0;
	logic [5:0] cfg_data = '0;

	lru_scoreboard sb;
	longint cycles = 0;
	bit stim_done = 0;
	bit [63:0] addr_pool [16];

	always #2 clk = ~clk;

	set_assoc_lru_cache_sim u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Mostly short gaps, occasionally a long one
	function int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Sample at the rising edge: count cycles, note accepted beats
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n && in_valid && in_ready) sb.note_access(in_data);
		if (arst_n && out_valid && out_ready) sb.check_beat(out_data);
		if (cycles > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Receiver: random backpressure, changed on the falling edge
	initial begin
		int g;
		forever begin
			@(negedge clk);
			out_ready <= 1;
			@(posedge clk);
			while (!(out_valid && out_ready)) @(posedge clk);
			g = pick_gap();
			if (g > 0) begin
				@(negedge clk);
				out_ready <= 0;
				repeat (g - 1) @(negedge clk);
			end
		end
	end

	// Drive one request beat; hold valid and payload until accepted
	task automatic send_beat(bit [1:0] op, bit [63:0] addr, bit no_gap = 0);
		int g;
		g = no_gap ? 0 : pick_gap();
		repeat (g) @(negedge clk);
		@(negedge clk);
		in_valid <= 1;
		in_data <= '{operation: op, address: addr};
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
		in_valid <= 0;
	endtask

	// Wait for all responses, then let the pipe drain before register writes
	task automatic drain();
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(bit [1:0] idx, bit [5:0] val);
		drain();
		@(negedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		sb.write_reg(idx, val);
		@(negedge clk);
		cfg_we <= 0;
	endtask

	task automatic set_cfg(bit [5:0] s, bit [5:0] w, bit [5:0] b);
		write_reg(salc_pkg::REG_SET_BITS, s);
		write_reg(salc_pkg::REG_WAYS, w);
		write_reg(salc_pkg::REG_BLOCK_BITS, b);
	endtask

	function bit [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	initial begin
		int n, k;
		bit [1:0] op;
		sb = new();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// Directed: extremes of address, all ops including the unknown one,
		// repeated hits, eviction in a one-way set
		send_beat(2'd0, 64'h0);
		send_beat(2'd0, 64'h0);
		send_beat(2'd1, 64'hFFFF_FFFF_FFFF_FFFF);
		send_beat(salc_pkg::OP_MODIFY, 64'hFFFF_FFFF_FFFF_FFFF);
		send_beat(2'd3, 64'h8);
		send_beat(2'd0, 64'h0);
		// Tags that differ only above the kept tag width alias
		set_cfg(6'd0, 6'd0, 6'd0);
		send_beat(2'd0, 64'h1234);
		send_beat(2'd0, 64'h8000_0000_0000_1234);
		send_beat(2'd0, 64'h4000_0000_0000_1234);
		// Oversized set and way counts are clamped; oversized offset zeroes tag
		set_cfg(6'd7, 6'd15, 6'd60);
		send_beat(2'd0, 64'h5555_5555_5555_5555);
		send_beat(salc_pkg::OP_MODIFY, 64'hAAAA_AAAA_AAAA_AAAA);
		set_cfg(6'd6, 6'd8, 6'd63);
		send_beat(2'd1, 64'hFFFF_FFFF_FFFF_FFFF);
		send_beat(2'd0, 64'h0);
		// Back to two sets with full associativity; ten distinct lines all map to set 0
		set_cfg(6'd1, 6'd8, 6'd1);
		for (k = 0; k < 10; k++) send_beat(2'(k % 3), 64'(k * 4), 1);

		// Random phases over several settings; addresses mostly from a small
		// pool so sets fill, hit and evict, with some full-range noise
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: set_cfg(6'd1, 6'd1, 6'd1);
				1: set_cfg(6'd6, 6'd8, 6'd1);
				2: set_cfg(6'd2, 6'd4, 6'd4);
				3: set_cfg(6'd0, 6'd2, 6'd32);
				default: set_cfg(6'($urandom_range(0, 7)), 6'($urandom_range(0, 15)),
					6'($urandom_range(0, 63)));
			endcase
			foreach (addr_pool[i])
				addr_pool[i] = ($urandom_range(0, 3) == 0) ? rand64()
					: 64'($urandom_range(0, 255)) << $urandom_range(0, 8);
			n = RAND_BEATS / 8;
			for (k = 0; k < n; k++) begin
				op = 2'($urandom_range(0, 3));
				if ($urandom_range(0, 9) < 8)
					send_beat(op, addr_pool[$urandom_range(0, 15)]);
				else
					send_beat(op, rand64());
				// Hold off once per phase until every response is back
				if (k == n / 2) while (sb.pending.size() != 0) @(posedge clk);
			end
		end

		drain();
		repeat (20) @(posedge clk);
		if (sb.errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule
